// ===== sv/gyro_yaw_integrator_assert.svh =====
// assertion macros for the yaw integrator assertion checker
`ifndef GYRO_YAW_INTEGRATOR_ASSERT_SVH
`define GYRO_YAW_INTEGRATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GYI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gyi: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define GYI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gyi: next-cycle check failed");

`endif

// ===== sv/gyi_pkg.sv =====
`default_nettype none

package gyi_pkg;

  // field widths
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned RATE_W    = 29;
  localparam int unsigned ANGLE_W   = 48;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned COUNT_W   = 8;

  // calibration and time base
  localparam int unsigned CAL_SAMPLES_DEF = 200;
  localparam int unsigned MS_PER_S        = 1000;

  // shared multiplier: a magnitude by the rate scale or by a time delta
  localparam int unsigned MUL_A_W = RATE_W;
  localparam int unsigned MUL_B_W = TIME_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // serial constant divider, several quotient bits per cycle
  localparam int unsigned DIVISOR_W  = 10;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DIV_STEPS  = 8;
  localparam int unsigned DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);
  localparam int unsigned QUOT_W     = 52;

  // command queue, depth a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned IN_FLIGHT_MAX = QUEUE_DEPTH + 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SIGN = 1'b1;
  localparam logic [SCALE_W-1:0]   RATE_SCALE_RST  = 16'd500;

  // mode codes on the input word
  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CAL    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_CAL    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [RAW_W-1:0]  raw_sample;
    logic [TIME_W-1:0]        now_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [RATE_W-1:0]  yaw_rate;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic                      bias_ready;
  } out_word_t;

  // classified command between front and back
  typedef struct packed {
    op_e                      op;
    logic signed [RAW_W-1:0]  raw;
    logic [RAW_W-1:0]         raw_mag;
    logic                     raw_neg;
    logic [TIME_W-1:0]        now_ms;
  } cmd_t;

  typedef struct packed {
    logic [SCALE_W-1:0] rate_scale;
    logic               invert_sign;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIVISOR_W-1:0] divisor;
    logic [DIV_W-1:0]     dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/gyi_stream_if.sv =====
`default_nettype none

interface gyi_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== sv/gyro_yaw_integrator.sv =====
`default_nettype none

// Gyro yaw integrator: every input word (mode, raw_sample, now_ms) yields one
// output word (yaw_rate, yaw_angle, bias_ready) in order. A start, clear or
// ordinary calibration word goes straight to the output state in the back end;
// the calibration word that completes a run and an update also pass through
// the shared 29x32 multiplier (twice for an update) and the constant divider that
// retires 8 quotient bits a cycle over a 64-bit dividend. A two-word command
// queue and a one-word output register let input and output stall on their
// own. The user must write rate_scale (index 0) and invert_sign (index 1) through
// the plain write port only while the block is idle, which it does not enforce.
// Rates are signed Q12.16 and the angle signed Q31.16, saturating.
module gyro_yaw_integrator #(
  parameter int unsigned CAL_SAMPLES = gyi_pkg::CAL_SAMPLES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  gyi_stream_if.sink                       in_i,
  gyi_stream_if.source                     out_o,
  input  logic                             cfg_we_i,
  input  logic [gyi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gyi_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  gyi_pkg::cfg_t     cfg_q, cfg_d;
  gyi_pkg::cmd_t     cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  gyi_pkg::div_req_t div_req;
  gyi_pkg::div_rsp_t div_rsp;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gyi_pkg::CFG_RATE_SCALE:  cfg_d.rate_scale  = cfg_wdata_i;
        gyi_pkg::CFG_INVERT_SIGN: cfg_d.invert_sign = cfg_wdata_i[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_scale  <= gyi_pkg::RATE_SCALE_RST;
      cfg_q.invert_sign <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gyi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pop_i       (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  gyi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  gyi_back #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== sv/gyi_front.sv =====
`default_nettype none

module gyi_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  gyi_stream_if.sink    in_i,
  input  logic          pop_i,
  output logic          cmd_valid_o,
  output gyi_pkg::cmd_t cmd_o
);

  gyi_pkg::cmd_t                 cmd_in;
  gyi_pkg::cmd_t                 q_mem_q [gyi_pkg::QUEUE_DEPTH];
  logic [gyi_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [gyi_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [gyi_pkg::QPTR_W:0]      fill_q, fill_d;
  logic                          push;

  // classify the incoming word
  always_comb begin
    cmd_in.raw     = in_i.payload.raw_sample;
    cmd_in.raw_neg = in_i.payload.raw_sample[gyi_pkg::RAW_W-1];
    cmd_in.raw_mag = in_i.payload.raw_sample[gyi_pkg::RAW_W-1] ?
                     gyi_pkg::RAW_W'(0) - in_i.payload.raw_sample :
                     in_i.payload.raw_sample;
    cmd_in.now_ms  = in_i.payload.now_ms;
    unique case (in_i.payload.mode)
      gyi_pkg::MODE_START:  cmd_in.op = gyi_pkg::OP_START;
      gyi_pkg::MODE_CAL:    cmd_in.op = gyi_pkg::OP_CAL;
      gyi_pkg::MODE_UPDATE: cmd_in.op = gyi_pkg::OP_UPDATE;
      gyi_pkg::MODE_CLEAR:  cmd_in.op = gyi_pkg::OP_CLEAR;
      default:              cmd_in.op = gyi_pkg::OP_START;
    endcase
  end

  // queue control
  assign in_i.ready  = (fill_q != (gyi_pkg::QPTR_W + 1)'(gyi_pkg::QUEUE_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + gyi_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + gyi_pkg::QPTR_W'(1) : rd_ptr_q;
    case ({push, pop_i})
      2'b10:   fill_d = fill_q + (gyi_pkg::QPTR_W + 1)'(1);
      2'b01:   fill_d = fill_q - (gyi_pkg::QPTR_W + 1)'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gyi_div.sv =====
`default_nettype none

module gyi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gyi_pkg::div_req_t req_i,
  output gyi_pkg::div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [gyi_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [gyi_pkg::DIV_W-1:0]       work_q, work_d, work_v;
  logic [gyi_pkg::DIVISOR_W-1:0]   rem_q, rem_d, rem_v;
  logic [gyi_pkg::DIVISOR_W-1:0]   divisor_q, divisor_d;
  logic [gyi_pkg::DIVISOR_W:0]     trial;

  // restoring division, several quotient bits per cycle; the remainder
  // stays below the divisor, quotient bits shift in behind the dividend
  always_comb begin
    rem_v  = rem_q;
    work_v = work_q;
    trial  = '0;
    for (int i = 0; i < gyi_pkg::DIV_STEPS; i++) begin
      trial  = {rem_v, work_v[gyi_pkg::DIV_W-1]};
      work_v = {work_v[gyi_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        rem_v     = gyi_pkg::DIVISOR_W'(trial - {1'b0, divisor_q});
        work_v[0] = 1'b1;
      end else begin
        rem_v = trial[gyi_pkg::DIVISOR_W-1:0];
      end
    end
  end

  // iteration control
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    work_d    = work_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = '0;
      work_d    = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      work_d = work_v;
      rem_d  = rem_v;
      cnt_d  = cnt_q + gyi_pkg::DIV_CNT_W'(1);
      if (cnt_q == gyi_pkg::DIV_CNT_W'(gyi_pkg::DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = work_q;

endmodule

`default_nettype wire

// ===== sv/gyi_back.sv =====
`default_nettype none

module gyi_back #(
  parameter int unsigned CAL_SAMPLES = gyi_pkg::CAL_SAMPLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  gyi_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  input  gyi_pkg::cfg_t     cfg_i,
  output gyi_pkg::div_req_t div_req_o,
  input  gyi_pkg::div_rsp_t div_rsp_i,
  gyi_stream_if.source      out_o
);

  localparam int unsigned RATE_W  = gyi_pkg::RATE_W;
  localparam int unsigned ANGLE_W = gyi_pkg::ANGLE_W;
  localparam int unsigned QUOT_W  = gyi_pkg::QUOT_W;
  localparam int unsigned SUM_W   = gyi_pkg::SUM_W;
  localparam int unsigned ACC_W   = QUOT_W + 2;

  localparam logic [QUOT_W-1:0]  RATE_LIM    = QUOT_W'(1) << (RATE_W - 1);
  localparam logic [RATE_W-1:0]  RATE_MAX_V  = {1'b0, {(RATE_W - 1){1'b1}}};
  localparam logic [RATE_W-1:0]  RATE_MIN_V  = {1'b1, {(RATE_W - 1){1'b0}}};
  localparam logic [ANGLE_W-1:0] ANGLE_MAX_V = {1'b0, {(ANGLE_W - 1){1'b1}}};
  localparam logic [ANGLE_W-1:0] ANGLE_MIN_V = {1'b1, {(ANGLE_W - 1){1'b0}}};

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_CAL_PREP  = 11'b000_0000_0010,
    ST_MUL_SCALE = 11'b000_0000_0100,
    ST_SAT       = 11'b000_0000_1000,
    ST_SUB       = 11'b000_0001_0000,
    ST_MUL_DIV   = 11'b000_0010_0000,
    ST_DIV_GO    = 11'b000_0100_0000,
    ST_DIV_WAIT  = 11'b000_1000_0000,
    ST_BIAS      = 11'b001_0000_0000,
    ST_ACC       = 11'b010_0000_0000,
    ST_DONE      = 11'b100_0000_0000
  } state_e;

  // sign and magnitude to a saturated rate
  function automatic logic [RATE_W-1:0] sat_rate(input logic neg,
                                                 input logic [QUOT_W-1:0] mag);
    logic [RATE_W-1:0] res;
    if (neg) begin
      res = (mag >= RATE_LIM) ? RATE_MIN_V : RATE_W'(0) - mag[RATE_W-1:0];
    end else begin
      res = (mag > RATE_LIM - QUOT_W'(1)) ? RATE_MAX_V : mag[RATE_W-1:0];
    end
    return res;
  endfunction

  state_e                              state_q, state_d;
  logic [SUM_W-1:0]                    sum_q, sum_d;
  logic [gyi_pkg::COUNT_W-1:0]         count_q, count_d;
  logic [RATE_W-1:0]                   bias_q, bias_d;
  logic                                bias_valid_q, bias_valid_d;
  logic [gyi_pkg::TIME_W-1:0]          last_time_q, last_time_d;
  logic [RATE_W-1:0]                   rate_q, rate_d;
  logic [ANGLE_W-1:0]                  yaw_q, yaw_d;
  logic                                out_valid_q, out_valid_d;
  gyi_pkg::out_word_t                  out_word_q, out_word_d;

  logic [gyi_pkg::MUL_A_W-1:0]         mul_a_q, mul_a_d;
  logic [gyi_pkg::MUL_B_W-1:0]         mul_b_q, mul_b_d;
  logic [gyi_pkg::PROD_W-1:0]          prod_q, prod_d;
  logic [RATE_W-1:0]                   scaled_q, scaled_d;
  logic [gyi_pkg::TIME_W-1:0]          dt_q, dt_d;
  logic                                neg_q, neg_d;
  logic                                cal_job_q, cal_job_d;

  logic [gyi_pkg::PROD_W-1:0]          mul_p;
  logic [gyi_pkg::COUNT_W-1:0]         count_inc;
  logic [SUM_W-1:0]                    sum_add;
  logic [SUM_W-1:0]                    sum_mag;
  logic [RATE_W:0]                     diff;
  logic [RATE_W-1:0]                   rate_sat;
  logic [RATE_W-1:0]                   rate_mag;
  logic [gyi_pkg::DIVISOR_W-1:0]       divisor;
  logic [QUOT_W-1:0]                   quot;
  logic [ACC_W-1:0]                    acc_yaw, acc_step, acc_sum;
  logic                                acc_fits;
  logic [ANGLE_W-1:0]                  yaw_sat;

  // shared multiplier
  assign mul_p = mul_a_q * mul_b_q;

  // calibration accumulate
  assign count_inc = count_q + gyi_pkg::COUNT_W'(1);
  assign sum_add   = sum_q + {{(SUM_W - gyi_pkg::RAW_W){cmd_i.raw[gyi_pkg::RAW_W-1]}},
                              cmd_i.raw};
  assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(0) - sum_q : sum_q;

  // bias-corrected rate, saturated
  assign diff     = {scaled_q[RATE_W-1], scaled_q} - {bias_q[RATE_W-1], bias_q};
  assign rate_sat = (diff[RATE_W] == diff[RATE_W-1]) ? diff[RATE_W-1:0] :
                    (diff[RATE_W] ? RATE_MIN_V : RATE_MAX_V);
  assign rate_mag = rate_sat[RATE_W-1] ? RATE_W'(0) - rate_sat : rate_sat;

  // divider request: bias by sample count, angle step by ms per second
  assign divisor = cal_job_q ? gyi_pkg::DIVISOR_W'(CAL_SAMPLES) :
                               gyi_pkg::DIVISOR_W'(gyi_pkg::MS_PER_S);
  assign div_req_o.start    = (state_q == ST_DIV_GO);
  assign div_req_o.divisor  = divisor;
  assign div_req_o.dividend = gyi_pkg::DIV_W'(prod_q) +
                              gyi_pkg::DIV_W'(divisor >> 1);
  assign quot = div_rsp_i.quotient[QUOT_W-1:0];

  // angle accumulate with saturation
  assign acc_yaw  = {{(ACC_W - ANGLE_W){yaw_q[ANGLE_W-1]}}, yaw_q};
  assign acc_step = {{(ACC_W - QUOT_W){1'b0}}, quot};
  assign acc_sum  = neg_q ? acc_yaw - acc_step : acc_yaw + acc_step;
  assign acc_fits = (&acc_sum[ACC_W-1:ANGLE_W-1]) || !(|acc_sum[ACC_W-1:ANGLE_W-1]);
  assign yaw_sat  = acc_fits ? acc_sum[ANGLE_W-1:0] :
                    (acc_sum[ACC_W-1] ? ANGLE_MIN_V : ANGLE_MAX_V);

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    count_d      = count_q;
    bias_d       = bias_q;
    bias_valid_d = bias_valid_q;
    last_time_d  = last_time_q;
    rate_d       = rate_q;
    yaw_d        = yaw_q;
    mul_a_d      = mul_a_q;
    mul_b_d      = mul_b_q;
    prod_d       = prod_q;
    scaled_d     = scaled_q;
    dt_d         = dt_q;
    neg_d        = neg_q;
    cal_job_d    = cal_job_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_word_d   = out_word_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            gyi_pkg::OP_START: begin
              last_time_d = cmd_i.now_ms;
              state_d     = ST_DONE;
            end
            gyi_pkg::OP_CAL: begin
              sum_d   = sum_add;
              count_d = count_inc;
              state_d = (count_inc == gyi_pkg::COUNT_W'(CAL_SAMPLES)) ? ST_CAL_PREP :
                                                                      ST_DONE;
            end
            gyi_pkg::OP_UPDATE: begin
              dt_d        = cmd_i.now_ms - last_time_q;
              last_time_d = cmd_i.now_ms;
              mul_a_d     = gyi_pkg::MUL_A_W'(cmd_i.raw_mag);
              mul_b_d     = gyi_pkg::MUL_B_W'(cfg_i.rate_scale);
              neg_d       = cmd_i.raw_neg ^ cfg_i.invert_sign;
              state_d     = ST_MUL_SCALE;
            end
            gyi_pkg::OP_CLEAR: begin
              yaw_d   = '0;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CAL_PREP: begin
        mul_a_d   = gyi_pkg::MUL_A_W'(sum_mag);
        mul_b_d   = gyi_pkg::MUL_B_W'(cfg_i.rate_scale);
        neg_d     = sum_q[SUM_W-1] ^ cfg_i.invert_sign;
        cal_job_d = 1'b1;
        state_d   = ST_MUL_DIV;
      end
      ST_MUL_SCALE: begin
        prod_d  = mul_p;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        scaled_d = sat_rate(neg_q, prod_q[QUOT_W-1:0]);
        state_d  = ST_SUB;
      end
      ST_SUB: begin
        rate_d    = rate_sat;
        mul_a_d   = rate_mag;
        mul_b_d   = dt_q;
        neg_d     = rate_sat[RATE_W-1];
        cal_job_d = 1'b0;
        state_d   = ST_MUL_DIV;
      end
      ST_MUL_DIV: begin
        prod_d  = mul_p;
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp_i.done) begin
          state_d = cal_job_q ? ST_BIAS : ST_ACC;
        end
      end
      ST_BIAS: begin
        bias_d       = sat_rate(neg_q, quot);
        bias_valid_d = 1'b1;
        sum_d        = '0;
        count_d      = '0;
        state_d      = ST_DONE;
      end
      ST_ACC: begin
        yaw_d   = yaw_sat;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d           = 1'b1;
          out_word_d.yaw_rate   = rate_q;
          out_word_d.yaw_angle  = yaw_q;
          out_word_d.bias_ready = bias_valid_q;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // architectural state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sum_q        <= '0;
      count_q      <= '0;
      bias_q       <= '0;
      bias_valid_q <= 1'b0;
      last_time_q  <= '0;
      rate_q       <= '0;
      yaw_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sum_q        <= sum_d;
      count_q      <= count_d;
      bias_q       <= bias_d;
      bias_valid_q <= bias_valid_d;
      last_time_q  <= last_time_d;
      rate_q       <= rate_d;
      yaw_q        <= yaw_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // datapath operands
  always_ff @(posedge clk_i) begin
    mul_a_q    <= mul_a_d;
    mul_b_q    <= mul_b_d;
    prod_q     <= prod_d;
    scaled_q   <= scaled_d;
    dt_q       <= dt_d;
    neg_q      <= neg_d;
    cal_job_q  <= cal_job_d;
    out_word_q <= out_word_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

endmodule

`default_nettype wire

// ===== sv/gyi_checker.sv =====
`default_nettype none

`include "gyro_yaw_integrator_assert.svh"

module gyi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input gyi_pkg::out_word_t out_word_i
);

  localparam int unsigned PEND_W = $clog2(gyi_pkg::IN_FLIGHT_MAX + 1);

  logic [PEND_W-1:0] pending_q, pending_d;
  logic              bias_seen_q, bias_seen_d;
  logic              in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // words accepted but not yet answered
  always_comb begin
    case ({in_acc, out_acc})
      2'b10:   pending_d = pending_q + PEND_W'(1);
      2'b01:   pending_d = pending_q - PEND_W'(1);
      default: pending_d = pending_q;
    endcase
    bias_seen_d = bias_seen_q || (out_acc && out_word_i.bias_ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      bias_seen_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      bias_seen_q <= bias_seen_d;
    end
  end

  `GYI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i))
  `GYI_ASSERT_IMP(a_no_orphan_word, clk_i, rst_ni, out_valid_i, pending_q != '0)
  `GYI_ASSERT_IMP(a_capacity, clk_i, rst_ni, in_acc, pending_q < PEND_W'(gyi_pkg::IN_FLIGHT_MAX))
  `GYI_ASSERT_IMP(a_bias_sticky, clk_i, rst_ni, out_acc && bias_seen_q, out_word_i.bias_ready)

endmodule

bind gyro_yaw_integrator gyi_checker u_gyi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.payload)
);

`default_nettype wire

// ===== test/gyro_yaw_integrator_checker.sv =====
`timescale 1ns / 1ps

// watches both word channels and the register port, predicts every output
// word from its own model of the integrator and compares in order
module gyro_yaw_integrator_checker
  import gyi_pkg::*;
#(
  parameter int unsigned CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_word_t              in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_word_t             out_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam longint RATE_HI  = 64'sd268435455;
  localparam longint RATE_LO  = -64'sd268435456;
  localparam longint ANGLE_HI = 64'sd140737488355327;
  localparam longint ANGLE_LO = -64'sd140737488355328;

  // register copies
  logic [SCALE_W-1:0] scale;
  logic               invert;

  // integrator state
  longint             cal_sum;
  logic [COUNT_W-1:0] cal_count;
  longint             bias;
  logic               bias_ok;
  logic [TIME_W-1:0]  mark_ms;
  longint             rate;
  longint             yaw;

  out_word_t          yaw_words_q[$];
  out_word_t          want;
  int                 errors;
  int                 pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint unsigned mag;
    longint unsigned q;
    if (num < 0) mag = -num;
    else mag = num;
    q = (mag + den / 2) / den;
    if (num < 0) return -longint'(q);
    return longint'(q);
  endfunction

  function automatic longint orient(longint v);
    return clip(invert ? -v : v, RATE_LO, RATE_HI);
  endfunction

  // apply one input word to the state, return the word it produces
  function automatic out_word_t integrate(in_word_t w);
    longint            sample;
    longint            scaled;
    longint            prod;
    longint            n;
    logic [TIME_W-1:0] span;
    out_word_t         res;
    sample = longint'($signed(w.raw_sample));
    case (w.mode)
      MODE_START: begin
        mark_ms = w.now_ms;
      end
      MODE_CAL: begin
        cal_sum   = cal_sum + sample;
        cal_count = cal_count + 1'b1;
        if (cal_count >= CAL_SAMPLES || cal_count == 0) begin
          n       = (cal_count != 0) ? longint'(cal_count) : 256;
          prod    = cal_sum * longint'(scale);
          bias    = orient(round_div(prod, n));
          bias_ok = 1'b1;
          cal_sum   = 0;
          cal_count = '0;
        end
      end
      MODE_UPDATE: begin
        span    = w.now_ms - mark_ms;
        mark_ms = w.now_ms;
        scaled  = orient(sample * longint'(scale));
        rate    = clip(scaled - bias, RATE_LO, RATE_HI);
        yaw     = clip(yaw + round_div(rate * longint'(span), MS_PER_S), ANGLE_LO, ANGLE_HI);
      end
      default: begin
        yaw = 0;
      end
    endcase
    res.yaw_rate   = rate[RATE_W-1:0];
    res.yaw_angle  = yaw[ANGLE_W-1:0];
    res.bias_ready = bias_ok;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale     = RATE_SCALE_RST;
      invert    = 1'b0;
      cal_sum   = 0;
      cal_count = '0;
      bias      = 0;
      bias_ok   = 1'b0;
      mark_ms   = '0;
      rate      = 0;
      yaw       = 0;
      yaw_words_q.delete();
      errors    = 0;
      pending   = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RATE_SCALE) scale = cfg_wdata_i[SCALE_W-1:0];
        else if (cfg_idx_i == CFG_INVERT_SIGN) invert = cfg_wdata_i[0];
      end

      // compare each output word with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (yaw_words_q.size() == 0) begin
          errors++;
          $display("%0t: output word with none predicted: rate %0d angle %0d ready %0b",
                   $time, $signed(out_word_i.yaw_rate), $signed(out_word_i.yaw_angle),
                   out_word_i.bias_ready);
        end else begin
          want = yaw_words_q.pop_front();
          if (want.yaw_rate !== out_word_i.yaw_rate) begin
            errors++;
            $display("%0t: yaw_rate expected %0d, got %0d", $time,
                     $signed(want.yaw_rate), $signed(out_word_i.yaw_rate));
          end
          if (want.yaw_angle !== out_word_i.yaw_angle) begin
            errors++;
            $display("%0t: yaw_angle expected %0d, got %0d", $time,
                     $signed(want.yaw_angle), $signed(out_word_i.yaw_angle));
          end
          if (want.bias_ready !== out_word_i.bias_ready) begin
            errors++;
            $display("%0t: bias_ready expected %0b, got %0b", $time,
                     want.bias_ready, out_word_i.bias_ready);
          end
        end
      end

      // predict the word for each accepted input
      if (in_valid_i && in_ready_i) yaw_words_q.push_back(integrate(in_word_i));
      pending = yaw_words_q.size();
    end
  end

endmodule

// ===== test/tb_gyro_yaw_integrator.sv =====
`timescale 1ns / 1ps

module tb_gyro_yaw_integrator;
  import gyi_pkg::*;

  localparam int unsigned CAL_N       = CAL_SAMPLES_DEF;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          PHASES      = 6;
  localparam int          MIXED_WORDS = 150;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    errors;
  int                    pending;
  int                    cycle_count;

  gyi_stream_if #(.payload_t(in_word_t))  req_if ();
  gyi_stream_if #(.payload_t(out_word_t)) rsp_if ();

  gyro_yaw_integrator #(
    .CAL_SAMPLES (CAL_N)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (req_if),
    .out_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  gyro_yaw_integrator_checker #(
    .CAL_SAMPLES (CAL_N)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_i  (req_if.ready),
    .in_word_i   (req_if.payload),
    .out_valid_i (rsp_if.valid),
    .out_ready_i (rsp_if.ready),
    .out_word_i  (rsp_if.payload),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[gyro_yaw_integrator] ERROR");
      $finish;
    end
  end

  // output side: random stalls per word, with calm stretches
  initial begin
    int stall;
    bit calm;
    rsp_if.ready = 1'b0;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  bit src_calm;

  // send one word after a random gap, return at the falling edge after it is taken
  task automatic push_word(input logic [MODE_W-1:0] mode, input int raw,
                           input logic [TIME_W-1:0] now);
    in_word_t w;
    int gap;
    w.mode       = mode;
    w.raw_sample = raw[RAW_W-1:0];
    w.now_ms     = now;
    if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // both registers, only once every word has come back
  task automatic write_cfg(input logic [SCALE_W-1:0] scale, input logic invert);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_RATE_SCALE;
    cfg_wdata <= scale;
    @(negedge clk_i);
    cfg_idx   <= CFG_INVERT_SIGN;
    cfg_wdata <= CFG_DATA_W'(invert);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase_scale [PHASES] = '{500, 65535, 1, 0, 500, 65535};
    bit          phase_inv   [PHASES] = '{0, 1, 1, 0, 0, 1};
    bit          phase_cal   [PHASES] = '{1, 0, 1, 0, 1, 0};
    logic [TIME_W-1:0] now;
    logic [MODE_W-1:0] mode;
    int offset;
    int style;
    int raw;
    int pick;

    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    src_calm       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // update before start and before calibration, raw extremes, zero span
    push_word(MODE_UPDATE, 1000, 32'd5);
    push_word(MODE_UPDATE, 32767, 32'd1005);
    push_word(MODE_UPDATE, -32768, 32'd2005);
    push_word(MODE_UPDATE, 0, 32'd2005);
    // timestamp wrap across zero
    push_word(MODE_START, 16'h5a5a, 32'hFFFF_FFF0);
    push_word(MODE_UPDATE, 16'h5555, 32'h0000_0010);
    push_word(MODE_UPDATE, 16'hAAAA, 32'hFFFF_FFFF);
    push_word(MODE_CLEAR, 0, 32'd0);
    // partial calibration run that carries into later runs
    push_word(MODE_CAL, 32767, 32'd0);
    push_word(MODE_CAL, -32768, 32'd0);
    push_word(MODE_START, 0, 32'd0);
    push_word(MODE_UPDATE, 100, 32'hFFFF_FFFF);
    push_word(MODE_CLEAR, 1, 32'd5);

    // full scale, longest spans: angle saturates both ways
    write_cfg(16'hFFFF, 1'b0);
    push_word(MODE_START, 0, 32'd0);
    push_word(MODE_UPDATE, 32767, 32'hFFFF_FFFF);
    push_word(MODE_UPDATE, 32767, 32'hFFFF_FFFE);
    push_word(MODE_CLEAR, -1, 32'd0);
    push_word(MODE_UPDATE, -32768, 32'hFFFF_FFFD);
    push_word(MODE_UPDATE, -32768, 32'hFFFF_FFFC);
    // negated full scale saturates the rate
    write_cfg(16'hFFFF, 1'b1);
    push_word(MODE_UPDATE, 32767, 32'hFFFF_FFFD);
    push_word(MODE_UPDATE, -32768, 32'hFFFF_FFFE);

    // random phases over several register settings
    now = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 4) phase_scale[ph] = $urandom_range(2, 65534);
      write_cfg(phase_scale[ph][SCALE_W-1:0], phase_inv[ph]);
      offset = int'($urandom_range(0, 6000)) - 3000;

      // a whole calibration run
      if (phase_cal[ph]) begin
        style = $urandom_range(0, 2);
        pick  = $urandom_range(0, 1);
        for (int k = 0; k < CAL_N; k++) begin
          case (style)
            0:       raw = offset + int'($urandom_range(0, 400)) - 200;
            1:       raw = int'($urandom);
            default: raw = pick ? 32767 : -32768;
          endcase
          now = now + $urandom_range(0, 20);
          push_word(MODE_CAL, raw, now);
        end
      end

      // mixed traffic: mostly updates, some starts, samples and clears
      for (int k = 0; k < MIXED_WORDS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) mode = MODE_START;
        else if (pick < 25) mode = MODE_CAL;
        else if (pick < 90) mode = MODE_UPDATE;
        else mode = MODE_CLEAR;
        if ($urandom_range(0, 7) == 0) raw = int'($urandom);
        else raw = offset + int'($urandom_range(0, 400)) - 200;
        pick = $urandom_range(0, 15);
        if (pick == 0) now = $urandom;
        else if (pick == 1) now = now - $urandom_range(0, 5);
        else now = now + $urandom_range(0, 40);
        push_word(mode, raw, now);
      end
    end

    // drain, then let the pipeline settle
    wait_idle();
    repeat (40) @(negedge clk_i);
    if (errors == 0) begin
      $display("[gyro_yaw_integrator] OK");
    end else begin
      $display("[gyro_yaw_integrator] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/gyi_pkg.sv
sv/gyi_stream_if.sv
sv/gyi_front.sv
sv/gyi_div.sv
sv/gyi_back.sv
sv/gyro_yaw_integrator.sv
sv/gyi_checker.sv
test/gyro_yaw_integrator_checker.sv
test/tb_gyro_yaw_integrator.sv
